// File: sv/gaps_pkg.sv
// Shared constants, controller state codes and handshake structs for the grid path search.
// No dependencies; every other file imports this package.
`default_nettype none
package gaps_pkg;
  // parameter defaults
  localparam int GRID_ROWS_DEF  = 8;
  localparam int GRID_COLS_DEF  = 8;
  localparam int HEAP_DEPTH_DEF = 256;

  // fixed field widths
  localparam int CELL_W  = 6;
  localparam int CVAL_W  = 4;
  localparam int COORD_W = 3;
  localparam int COST_W  = 7;
  localparam int SEQ_W   = 9;
  localparam int KEY_W   = COST_W + SEQ_W + CELL_W;
  localparam int DIM_W   = 4;
  localparam int MASK_W  = 16;
  localparam int DIR_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [COST_W-1:0] COST_INF = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK = 2'd2;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // step directions
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  // controller states, also the datapath command code
  localparam int STATE_W = 5;
  localparam logic [STATE_W-1:0] S_IDLE     = 5'd0;
  localparam logic [STATE_W-1:0] S_QINIT    = 5'd1;
  localparam logic [STATE_W-1:0] S_PU_CHK   = 5'd2;
  localparam logic [STATE_W-1:0] S_PU_UP    = 5'd3;
  localparam logic [STATE_W-1:0] S_PU_CMP   = 5'd4;
  localparam logic [STATE_W-1:0] S_PO_BEGIN = 5'd5;
  localparam logic [STATE_W-1:0] S_PO_TOP   = 5'd6;
  localparam logic [STATE_W-1:0] S_PO_LAST  = 5'd7;
  localparam logic [STATE_W-1:0] S_PO_SIFT  = 5'd8;
  localparam logic [STATE_W-1:0] S_PO_L     = 5'd9;
  localparam logic [STATE_W-1:0] S_PO_R     = 5'd10;
  localparam logic [STATE_W-1:0] S_CUR      = 5'd11;
  localparam logic [STATE_W-1:0] S_EX_G     = 5'd12;
  localparam logic [STATE_W-1:0] S_EX_DIR   = 5'd13;
  localparam logic [STATE_W-1:0] S_EX_CHK   = 5'd14;
  localparam logic [STATE_W-1:0] S_EX_NEXT  = 5'd15;
  localparam logic [STATE_W-1:0] S_TR_W     = 5'd16;
  localparam logic [STATE_W-1:0] S_TR_P     = 5'd17;
  localparam logic [STATE_W-1:0] S_EM_RD    = 5'd18;
  localparam logic [STATE_W-1:0] S_EM_OUT   = 5'd19;
  localparam logic [STATE_W-1:0] S_NOPATH   = 5'd20;

  typedef struct packed {
    logic               accept;
    logic [STATE_W-1:0] op;
  } gaps_cmd_t;

  typedef struct packed {
    logic q_bad;
    logic push_full;
    logic pu_i_zero;
    logic pu_stop;
    logic cnt_zero;
    logic cnt_one;
    logic cur_skip;
    logic cur_goal;
    logic dir_out;
    logic dir_last;
    logic nb_take;
    logic sift_end;
    logic right_ok;
    logic sift_stop;
    logic tr_end;
    logic tr_bad;
    logic em_last;
    logic out_pending;
  } gaps_sts_t;

  function automatic logic [COORD_W-1:0] coord_dist(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
    coord_dist = (a > b) ? (a - b) : (b - a);
  endfunction
endpackage
`default_nettype wire

// File: sv/grid_astar_path_search.sv
// Top level of the grid path search: joins the gaps_ctrl sequencer and the gaps_dp datapath.
// Depends on gaps_pkg, gaps_ctrl and gaps_dp.
//
//   channel   direction  handshake                       payload
//   item      in         start_i & !busy_o               opcode, cell_*, start_*, end_*
//   result    out        path_valid_o (one-cycle strobe) path_row/col, path_found, last_of_path
//   config    in         cfg_valid_i & cfg_ready_o       cfg_index_i, cfg_data_i
//
// A write item is stored when accepted and leaves the block idle. A query runs the heap
// search one memory access per cycle: a push sifts up and a pop sifts down one heap level
// per step, each expanded node checks its four neighbours and pushes those it takes, and
// the path is then traced back from the goal and emitted cell by cell from the start.
// Reset is asynchronous and clears the grid valid bits; no clearing pass is needed.
// busy_o stays high until the final result strobe; the receiver cannot stall results.
`default_nettype none
module grid_astar_path_search #(
  parameter int GRID_ROWS  = gaps_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS  = gaps_pkg::GRID_COLS_DEF,
  parameter int HEAP_DEPTH = gaps_pkg::HEAP_DEPTH_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  output logic                          busy_o,
  input  wire                           opcode_i,
  input  wire [gaps_pkg::COORD_W-1:0]   cell_row_i,
  input  wire [gaps_pkg::COORD_W-1:0]   cell_col_i,
  input  wire [gaps_pkg::CVAL_W-1:0]    cell_value_i,
  input  wire [gaps_pkg::COORD_W-1:0]   start_row_i,
  input  wire [gaps_pkg::COORD_W-1:0]   start_col_i,
  input  wire [gaps_pkg::COORD_W-1:0]   end_row_i,
  input  wire [gaps_pkg::COORD_W-1:0]   end_col_i,
  output logic                          path_valid_o,
  output logic [gaps_pkg::COORD_W-1:0]  path_row_o,
  output logic [gaps_pkg::COORD_W-1:0]  path_col_o,
  output logic                          path_found_o,
  output logic                          last_of_path_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [gaps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [gaps_pkg::MASK_W-1:0]    cfg_data_i
);
  import gaps_pkg::*;

  gaps_cmd_t cmd;
  gaps_sts_t sts;

  // registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  gaps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  gaps_dp #(
    .GRID_ROWS  (GRID_ROWS),
    .GRID_COLS  (GRID_COLS),
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .cell_row_i     (cell_row_i),
    .cell_col_i     (cell_col_i),
    .cell_value_i   (cell_value_i),
    .start_row_i    (start_row_i),
    .start_col_i    (start_col_i),
    .end_row_i      (end_row_i),
    .end_col_i      (end_col_i),
    .path_valid_o   (path_valid_o),
    .path_row_o     (path_row_o),
    .path_col_o     (path_col_o),
    .path_found_o   (path_found_o),
    .last_of_path_o (last_of_path_o)
  );
endmodule
`default_nettype wire

// File: sv/gaps_ctrl.sv
// Sequencer of the grid path search: walks push, pop, expand, trace and emit steps.
// Depends on gaps_pkg; drives gaps_dp through a command struct.
`default_nettype none
module gaps_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire                opcode_i,
  input  gaps_pkg::gaps_sts_t sts_i,
  output gaps_pkg::gaps_cmd_t cmd_o,
  output logic               busy_o
);
  import gaps_pkg::*;

  logic [STATE_W-1:0] state_q, state_d;
  logic               ret_q, ret_d;
  logic [STATE_W-1:0] ret_state;
  logic               accept;

  assign busy_o    = (state_q != S_IDLE) || sts_i.out_pending;
  assign accept    = start_i && !busy_o;
  assign ret_state = ret_q ? S_EX_NEXT : S_PO_BEGIN;
  assign cmd_o.accept = accept;
  assign cmd_o.op     = state_q;

  // choose the next step
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      S_IDLE:     if (accept && opcode_i == OP_QUERY) state_d = S_QINIT;
      S_QINIT: begin
        ret_d   = 1'b0;
        state_d = sts_i.q_bad ? S_NOPATH : S_PU_CHK;
      end
      S_PU_CHK:   state_d = sts_i.push_full ? ret_state : S_PU_UP;
      S_PU_UP:    state_d = sts_i.pu_i_zero ? ret_state : S_PU_CMP;
      S_PU_CMP:   state_d = sts_i.pu_stop ? ret_state : S_PU_UP;
      S_PO_BEGIN: state_d = sts_i.cnt_zero ? S_NOPATH : S_PO_TOP;
      S_PO_TOP:   state_d = sts_i.cnt_one ? S_CUR : S_PO_LAST;
      S_PO_LAST:  state_d = S_PO_SIFT;
      S_PO_SIFT:  state_d = sts_i.sift_end ? S_CUR : S_PO_L;
      S_PO_L: begin
        if (sts_i.right_ok) state_d = S_PO_R;
        else                state_d = sts_i.sift_stop ? S_CUR : S_PO_SIFT;
      end
      S_PO_R:     state_d = sts_i.sift_stop ? S_CUR : S_PO_SIFT;
      S_CUR: begin
        if (sts_i.cur_skip)      state_d = S_PO_BEGIN;
        else if (sts_i.cur_goal) state_d = S_TR_W;
        else                     state_d = S_EX_G;
      end
      S_EX_G:     state_d = S_EX_DIR;
      S_EX_DIR:   state_d = sts_i.dir_out ? S_EX_NEXT : S_EX_CHK;
      S_EX_CHK: begin
        if (sts_i.nb_take) begin
          ret_d   = 1'b1;
          state_d = S_PU_CHK;
        end else begin
          state_d = S_EX_NEXT;
        end
      end
      S_EX_NEXT:  state_d = sts_i.dir_last ? S_PO_BEGIN : S_EX_DIR;
      S_TR_W:     state_d = sts_i.tr_end ? S_EM_RD : S_TR_P;
      S_TR_P:     state_d = sts_i.tr_bad ? S_EM_RD : S_TR_W;
      S_EM_RD:    state_d = S_EM_OUT;
      S_EM_OUT:   state_d = sts_i.em_last ? S_IDLE : S_EM_RD;
      S_NOPATH:   state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end
endmodule
`default_nettype wire

// File: sv/gaps_dp.sv
// Datapath of the grid path search: grid, cost, parent, heap and path memories plus registers.
// Depends on gaps_pkg; steered by gaps_ctrl commands.
`default_nettype none
module gaps_dp #(
  parameter int GRID_ROWS  = gaps_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS  = gaps_pkg::GRID_COLS_DEF,
  parameter int HEAP_DEPTH = gaps_pkg::HEAP_DEPTH_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  gaps_pkg::gaps_cmd_t            cmd_i,
  output gaps_pkg::gaps_sts_t            sts_o,
  input  wire                            cfg_valid_i,
  input  wire [gaps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [gaps_pkg::MASK_W-1:0]     cfg_data_i,
  input  wire                            opcode_i,
  input  wire [gaps_pkg::COORD_W-1:0]    cell_row_i,
  input  wire [gaps_pkg::COORD_W-1:0]    cell_col_i,
  input  wire [gaps_pkg::CVAL_W-1:0]     cell_value_i,
  input  wire [gaps_pkg::COORD_W-1:0]    start_row_i,
  input  wire [gaps_pkg::COORD_W-1:0]    start_col_i,
  input  wire [gaps_pkg::COORD_W-1:0]    end_row_i,
  input  wire [gaps_pkg::COORD_W-1:0]    end_col_i,
  output logic                           path_valid_o,
  output logic [gaps_pkg::COORD_W-1:0]   path_row_o,
  output logic [gaps_pkg::COORD_W-1:0]   path_col_o,
  output logic                           path_found_o,
  output logic                           last_of_path_o
);
  import gaps_pkg::*;

  localparam int CELLS  = GRID_ROWS * GRID_COLS;
  localparam int CIDX_W = $clog2(CELLS);
  localparam int NCNT_W = $clog2(CELLS + 1);
  localparam int HIDX_W = $clog2(HEAP_DEPTH);
  localparam int HC_W   = HIDX_W + 2;

  // split a cell index into row and column by compares against row starts
  function automatic logic [COORD_W-1:0] idx_row(input logic [CELL_W-1:0] idx);
    idx_row = '0;
    for (int k = 1; k < 8; k++)
      if (int'(idx) >= k * GRID_COLS) idx_row = COORD_W'(k);
  endfunction

  function automatic logic [COORD_W-1:0] idx_col(input logic [CELL_W-1:0] idx);
    idx_col = COORD_W'(int'(idx) - int'(idx_row(idx)) * GRID_COLS);
  endfunction

  logic [STATE_W-1:0] op;
  assign op = cmd_i.op;

  // configuration registers
  logic [DIM_W-1:0]  rows_q, cols_q;
  logic [MASK_W-1:0] mask_q;
  logic [DIM_W-1:0]  rows_eff, cols_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(8);
      cols_q <= DIM_W'(8);
      mask_q <= MASK_W'(300);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROWS: rows_q <= cfg_data_i[DIM_W-1:0];
        CFG_COLS: cols_q <= cfg_data_i[DIM_W-1:0];
        CFG_MASK: mask_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  assign rows_eff = (rows_q > DIM_W'(GRID_ROWS)) ? DIM_W'(GRID_ROWS) : rows_q;
  assign cols_eff = (cols_q > DIM_W'(GRID_COLS)) ? DIM_W'(GRID_COLS) : cols_q;

  // latch query endpoints
  logic [COORD_W-1:0] sr_q, sc_q, er_q, ec_q;
  logic [CELL_W-1:0]  start_cell, goal_cell;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sr_q <= start_row_i;
      sc_q <= start_col_i;
      er_q <= end_row_i;
      ec_q <= end_col_i;
    end
  end

  assign start_cell = CELL_W'(int'(sr_q) * GRID_COLS + int'(sc_q));
  assign goal_cell  = CELL_W'(int'(er_q) * GRID_COLS + int'(ec_q));

  // control registers of the search
  logic [HIDX_W:0]     cnt_q;
  logic [HIDX_W-1:0]   i_q;
  logic [SEQ_W-1:0]    seq_q;
  logic [DIR_W-1:0]    dir_q;
  logic [CELLS-1:0]    closed_q, cost_vld_q, cell_vld_q;
  logic [NCNT_W-1:0]   n_q, idx_q;
  logic                out_valid_q;

  // payload registers
  logic [KEY_W-1:0]    key_q, top_q, last_q, left_q;
  logic [COST_W-1:0]   pf_q, gcur_q;
  logic [CELL_W-1:0]   pcell_q, nb_q, p_q;
  logic [COORD_W-1:0]  cr_q, cc_q, nr_q, nc_q;
  logic [COORD_W-1:0]  out_row_q, out_col_q;
  logic                out_found_q, out_last_q;

  // memory read data
  logic [KEY_W-1:0]    heap_rd_q;
  logic [CVAL_W-1:0]   cell_rd_q;
  logic                cell_rv_q;
  logic [COST_W-1:0]   cost_rd_q;
  logic                cost_rv_q;
  logic [DIR_W-1:0]    par_rd_q;
  logic [CELL_W-1:0]   pbuf_rd_q;

  // query bounds
  logic q_bad;
  assign q_bad = ({1'b0, sr_q} >= rows_eff) || ({1'b0, sc_q} >= cols_eff) ||
                 ({1'b0, er_q} >= rows_eff) || ({1'b0, ec_q} >= cols_eff);

  // heap index arithmetic
  logic [KEY_W-1:0]  key_c;
  logic [HIDX_W-1:0] up_c;
  logic [HC_W-1:0]   l_w, r_w, cnt_w;
  logic [KEY_W-1:0]  sift_val;
  logic [HC_W-1:0]   sift_idx;
  logic              sift_stop;

  assign key_c = {pf_q, seq_q, pcell_q};
  assign up_c  = (i_q - HIDX_W'(1)) >> 1;
  assign l_w   = {1'b0, i_q, 1'b1};
  assign r_w   = l_w + HC_W'(1);
  assign cnt_w = {1'b0, cnt_q};

  // pick the smaller child for the sift step
  always_comb begin
    if (op == S_PO_R && heap_rd_q < left_q) begin
      sift_val = heap_rd_q;
      sift_idx = r_w;
    end else begin
      sift_val = (op == S_PO_R) ? left_q : heap_rd_q;
      sift_idx = l_w;
    end
  end
  assign sift_stop = sift_val >= last_q;

  // current node
  logic [CELL_W-1:0]  cur_c;
  logic               cur_oob, cur_skip;
  assign cur_c    = top_q[CELL_W-1:0];
  assign cur_oob  = int'(cur_c) >= CELLS;
  assign cur_skip = cur_oob ? 1'b1 : closed_q[cur_c[CIDX_W-1:0]];

  // neighbor of the current node
  logic               dir_out;
  logic [COORD_W-1:0] nr_c, nc_c;
  logic [CELL_W-1:0]  nb_c;

  always_comb begin
    nr_c    = cr_q;
    nc_c    = cc_q;
    dir_out = 1'b0;
    case (dir_q)
      DIR_UP: begin
        dir_out = (cr_q == '0);
        nr_c    = cr_q - COORD_W'(1);
      end
      DIR_DOWN: begin
        dir_out = ({1'b0, cr_q} + DIM_W'(1)) >= rows_eff;
        nr_c    = cr_q + COORD_W'(1);
      end
      DIR_LEFT: begin
        dir_out = (cc_q == '0);
        nc_c    = cc_q - COORD_W'(1);
      end
      DIR_RIGHT: begin
        dir_out = ({1'b0, cc_q} + DIM_W'(1)) >= cols_eff;
        nc_c    = cc_q + COORD_W'(1);
      end
      default: dir_out = 1'b1;
    endcase
  end
  assign nb_c = CELL_W'(int'(nr_c) * GRID_COLS + int'(nc_c));

  // relax test for the neighbor
  logic [CVAL_W-1:0] cval;
  logic [COST_W:0]   g_w, cost_nb, f_w;
  logic              nb_take;
  assign cval    = cell_rv_q ? cell_rd_q : '0;
  assign g_w     = {1'b0, gcur_q} + (COST_W + 1)'(1);
  assign cost_nb = {1'b0, (cost_rv_q ? cost_rd_q : COST_INF)};
  assign nb_take = mask_q[cval] && !closed_q[nb_q[CIDX_W-1:0]] && (g_w < cost_nb);
  assign f_w     = g_w + (COST_W + 1)'(coord_dist(nr_q, er_q)) +
                   (COST_W + 1)'(coord_dist(nc_q, ec_q));

  // step back along the parent direction
  logic [COORD_W-1:0] pr_q_c, pc_q_c, pr_c, pc_c;
  logic               tr_bad;
  assign pr_q_c = idx_row(p_q);
  assign pc_q_c = idx_col(p_q);

  always_comb begin
    pr_c   = pr_q_c;
    pc_c   = pc_q_c;
    tr_bad = 1'b0;
    case (par_rd_q)
      DIR_UP: begin
        tr_bad = int'(pr_q_c) + 1 >= GRID_ROWS;
        pr_c   = pr_q_c + COORD_W'(1);
      end
      DIR_DOWN: begin
        tr_bad = (pr_q_c == '0);
        pr_c   = pr_q_c - COORD_W'(1);
      end
      DIR_LEFT: begin
        tr_bad = int'(pc_q_c) + 1 >= GRID_COLS;
        pc_c   = pc_q_c + COORD_W'(1);
      end
      DIR_RIGHT: begin
        tr_bad = (pc_q_c == '0);
        pc_c   = pc_q_c - COORD_W'(1);
      end
      default: tr_bad = 1'b1;
    endcase
  end

  // status back to the controller
  always_comb begin
    sts_o.q_bad       = q_bad;
    sts_o.push_full   = int'(cnt_q) >= HEAP_DEPTH;
    sts_o.pu_i_zero   = (i_q == '0);
    sts_o.pu_stop     = heap_rd_q <= key_q;
    sts_o.cnt_zero    = (cnt_q == '0);
    sts_o.cnt_one     = (cnt_q == (HIDX_W + 1)'(1));
    sts_o.cur_skip    = cur_skip;
    sts_o.cur_goal    = (cur_c == goal_cell);
    sts_o.dir_out     = dir_out;
    sts_o.dir_last    = (dir_q == DIR_RIGHT);
    sts_o.nb_take     = nb_take;
    sts_o.sift_end    = l_w >= cnt_w;
    sts_o.right_ok    = r_w < cnt_w;
    sts_o.sift_stop   = sift_stop;
    sts_o.tr_end      = (p_q == start_cell) || (int'(n_q) + 1 == CELLS);
    sts_o.tr_bad      = tr_bad;
    sts_o.em_last     = (idx_q == '0);
    sts_o.out_pending = out_valid_q;
  end

  // heap port steering
  logic              heap_we;
  logic [HIDX_W-1:0] heap_wa, heap_ra;
  logic [KEY_W-1:0]  heap_wd;

  always_comb begin
    heap_we = 1'b0;
    heap_wa = i_q;
    heap_wd = key_q;
    heap_ra = '0;
    case (op)
      S_PU_UP: begin
        heap_ra = up_c;
        if (i_q == '0) heap_we = 1'b1;
      end
      S_PU_CMP: begin
        heap_we = 1'b1;
        if (!(heap_rd_q <= key_q)) heap_wd = heap_rd_q;
      end
      S_PO_TOP:  heap_ra = HIDX_W'(cnt_q - (HIDX_W + 1)'(1));
      S_PO_SIFT: begin
        heap_ra = l_w[HIDX_W-1:0];
        heap_wd = last_q;
        heap_we = (l_w >= cnt_w);
      end
      S_PO_L, S_PO_R: begin
        heap_ra = r_w[HIDX_W-1:0];
        heap_wd = sift_stop ? last_q : sift_val;
        heap_we = (op == S_PO_R) || !(r_w < cnt_w);
      end
      default: ;
    endcase
  end

  logic [KEY_W-1:0] heap_mem [HEAP_DEPTH];
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    heap_rd_q <= heap_mem[heap_ra];
  end

  // grid store
  logic              cell_we;
  logic [CIDX_W-1:0] cell_wa;
  assign cell_we = cmd_i.accept && (opcode_i == OP_WRITE) &&
                   (int'(cell_row_i) < GRID_ROWS) && (int'(cell_col_i) < GRID_COLS);
  assign cell_wa = CIDX_W'(int'(cell_row_i) * GRID_COLS + int'(cell_col_i));

  logic [CVAL_W-1:0] cell_mem [CELLS];
  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[cell_wa] <= cell_value_i;
    cell_rd_q <= cell_mem[nb_c[CIDX_W-1:0]];
    cell_rv_q <= cell_vld_q[nb_c[CIDX_W-1:0]];
  end

  // best cost store
  logic              cost_we;
  logic [CIDX_W-1:0] cost_wa, cost_ra;
  logic [COST_W-1:0] cost_wd;
  assign cost_we = (op == S_QINIT && !q_bad) || (op == S_EX_CHK && nb_take);
  assign cost_wa = (op == S_QINIT) ? start_cell[CIDX_W-1:0] : nb_q[CIDX_W-1:0];
  assign cost_wd = (op == S_QINIT) ? '0 : g_w[COST_W-1:0];
  assign cost_ra = (op == S_CUR) ? cur_c[CIDX_W-1:0] : nb_c[CIDX_W-1:0];

  logic [COST_W-1:0] cost_mem [CELLS];
  always_ff @(posedge clk_i) begin
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    cost_rd_q <= cost_mem[cost_ra];
    cost_rv_q <= cost_vld_q[cost_ra];
  end

  // parent direction store
  logic [DIR_W-1:0] par_mem [CELLS];
  always_ff @(posedge clk_i) begin
    if (op == S_EX_CHK && nb_take) par_mem[nb_q[CIDX_W-1:0]] <= dir_q;
    par_rd_q <= par_mem[p_q[CIDX_W-1:0]];
  end

  // path buffer, filled goal first and read back in reverse
  logic [CELL_W-1:0] pbuf_mem [CELLS];
  always_ff @(posedge clk_i) begin
    if (op == S_TR_W) pbuf_mem[n_q[CIDX_W-1:0]] <= p_q;
    pbuf_rd_q <= pbuf_mem[idx_q[CIDX_W-1:0]];
  end

  // valid bits and search counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_vld_q  <= '0;
      closed_q    <= '0;
      cost_vld_q  <= '0;
      cnt_q       <= '0;
      i_q         <= '0;
      seq_q       <= '0;
      dir_q       <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (op == S_EM_OUT) || (op == S_NOPATH);
      if (cell_we) cell_vld_q[cell_wa] <= 1'b1;
      case (op)
        S_QINIT: begin
          closed_q   <= '0;
          cost_vld_q <= q_bad ? '0 : CELLS'(1) << start_cell[CIDX_W-1:0];
          cnt_q <= '0;
          seq_q <= '0;
        end
        S_PU_CHK: begin
          if (int'(cnt_q) < HEAP_DEPTH) begin
            i_q   <= cnt_q[HIDX_W-1:0];
            cnt_q <= cnt_q + (HIDX_W + 1)'(1);
            seq_q <= seq_q + SEQ_W'(1);
          end
        end
        S_PU_CMP: if (!(heap_rd_q <= key_q)) i_q <= up_c;
        S_PO_TOP: begin
          cnt_q <= cnt_q - (HIDX_W + 1)'(1);
          i_q   <= '0;
        end
        S_PO_L: if (!(r_w < cnt_w) && !sift_stop) i_q <= sift_idx[HIDX_W-1:0];
        S_PO_R: if (!sift_stop) i_q <= sift_idx[HIDX_W-1:0];
        S_CUR: begin
          if (!cur_skip) closed_q[cur_c[CIDX_W-1:0]] <= 1'b1;
          dir_q <= DIR_UP;
          n_q   <= '0;
        end
        S_EX_CHK: if (nb_take) cost_vld_q[nb_q[CIDX_W-1:0]] <= 1'b1;
        S_EX_NEXT: dir_q <= dir_q + DIR_W'(1);
        S_TR_W: begin
          n_q   <= n_q + NCNT_W'(1);
          idx_q <= n_q;
        end
        S_EM_OUT: idx_q <= idx_q - NCNT_W'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (op)
      S_QINIT: begin
        pf_q    <= COST_W'(coord_dist(sr_q, er_q)) + COST_W'(coord_dist(sc_q, ec_q));
        pcell_q <= start_cell;
      end
      S_PU_CHK:  key_q  <= key_c;
      S_PO_TOP:  top_q  <= heap_rd_q;
      S_PO_LAST: last_q <= heap_rd_q;
      S_PO_L:    left_q <= heap_rd_q;
      S_CUR: begin
        cr_q <= idx_row(cur_c);
        cc_q <= idx_col(cur_c);
        p_q  <= cur_c;
      end
      S_EX_G: gcur_q <= cost_rv_q ? cost_rd_q : COST_INF;
      S_EX_DIR: begin
        nb_q <= nb_c;
        nr_q <= nr_c;
        nc_q <= nc_c;
      end
      S_EX_CHK: begin
        pf_q    <= f_w[COST_W-1:0];
        pcell_q <= nb_q;
      end
      S_TR_P: p_q <= CELL_W'(int'(pr_c) * GRID_COLS + int'(pc_c));
      S_EM_OUT: begin
        out_row_q   <= idx_row(pbuf_rd_q);
        out_col_q   <= idx_col(pbuf_rd_q);
        out_found_q <= 1'b1;
        out_last_q  <= (idx_q == '0);
      end
      S_NOPATH: begin
        out_row_q   <= '0;
        out_col_q   <= '0;
        out_found_q <= 1'b0;
        out_last_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign path_valid_o   = out_valid_q;
  assign path_row_o     = out_row_q;
  assign path_col_o     = out_col_q;
  assign path_found_o   = out_found_q;
  assign last_of_path_o = out_last_q;

  // heap never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= HEAP_DEPTH) else $error("heap count beyond depth");

  // a no-path answer is always the final result
  a_nopath_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> out_last_q) else $error("no-path not last");

  // nothing follows the last result of a query
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |=> !out_valid_q) else $error("result after last");
endmodule
`default_nettype wire

// File: sim/grid_astar_path_search_tb.sv
// Self-checking testbench for grid_astar_path_search: drives write and query items,
// predicts the path of each query with its own A* search, and checks every strobed cell.
// Depends on gaps_pkg and the grid_astar_path_search RTL.
`default_nettype none
module grid_astar_path_search_tb;
  import gaps_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               found;
    logic               last;
  } path_cell_t;

  // Path predictor and store of expected path cells
  class path_scoreboard;
    logic [CVAL_W-1:0]  grid [64];
    logic [DIM_W-1:0]   rows_cfg;
    logic [DIM_W-1:0]   cols_cfg;
    logic [MASK_W-1:0]  mask_cfg;
    path_cell_t         pending[$];
    int                 errors;

    function new();
      foreach (grid[i]) grid[i] = '0;
      rows_cfg = 4'd8;
      cols_cfg = 4'd8;
      mask_cfg = 16'd300;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] data);
      if (idx == CFG_ROWS) rows_cfg = data[DIM_W-1:0];
      else if (idx == CFG_COLS) cols_cfg = data[DIM_W-1:0];
      else if (idx == CFG_MASK) mask_cfg = data;
    endfunction

    function int mdist(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void push_miss();
      path_cell_t p;
      p = '{row: '0, col: '0, found: 1'b0, last: 1'b1};
      pending.insert(pending.size(), p);
    endfunction

    // Note an accepted item: update the grid, or search and queue the path
    function void note_item(logic op, int cr, int cc, int cv, int sr, int sc, int er, int ec);
      int rows, cols, start_c, goal, cnt, seq, best, bi, cur, r, c, nr, nc, nb, g, n;
      int key [$];
      bit closed [64];
      int cost [64];
      int pdir [64];
      int trail [64];
      int dr [4];
      int dc [4];
      path_cell_t p;
      dr = '{-1, 1, 0, 0};
      dc = '{0, 0, -1, 1};
      if (op == OP_WRITE) begin
        grid[cr * 8 + cc] = cv[CVAL_W-1:0];
        return;
      end
      rows = (rows_cfg > 4'd8) ? 8 : int'(rows_cfg);
      cols = (cols_cfg > 4'd8) ? 8 : int'(cols_cfg);
      if (sr >= rows || sc >= cols || er >= rows || ec >= cols) begin
        push_miss();
        return;
      end
      foreach (closed[i]) begin
        closed[i] = 0;
        cost[i] = 127;
        pdir[i] = 0;
      end
      start_c = sr * 8 + sc;
      goal = er * 8 + ec;
      cost[start_c] = 0;
      seq = 0;
      // open set as a list of packed f:seq:cell keys; minimum key pops first
      key.insert(key.size(), ((mdist(sr, er) + mdist(sc, ec)) << 15) | (seq << 6) | start_c);
      seq++;
      while (key.size() > 0) begin
        best = key[0];
        bi = 0;
        for (int k = 1; k < key.size(); k++)
          if (key[k] < best) begin
            best = key[k];
            bi = k;
          end
        key.delete(bi);
        cur = best & 63;
        if (closed[cur]) continue;
        closed[cur] = 1;
        if (cur == goal) begin
          n = 0;
          trail[n++] = cur;
          while (cur != start_c && n < 64) begin
            cur = (cur / 8 - dr[pdir[cur]]) * 8 + (cur % 8 - dc[pdir[cur]]);
            trail[n++] = cur;
          end
          for (int k = n - 1; k >= 0; k--) begin
            p.row = COORD_W'(trail[k] / 8);
            p.col = COORD_W'(trail[k] % 8);
            p.found = 1'b1;
            p.last = (k == 0);
            pending.insert(pending.size(), p);
          end
          return;
        end
        r = cur / 8;
        c = cur % 8;
        for (int d = 0; d < 4; d++) begin
          nr = r + dr[d];
          nc = c + dc[d];
          if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
          nb = nr * 8 + nc;
          if (!mask_cfg[grid[nb]] || closed[nb]) continue;
          g = cost[cur] + 1;
          if (g < cost[nb]) begin
            cost[nb] = g;
            pdir[nb] = d;
            // heap full drops the push
            if (key.size() < 256) begin
              key.insert(key.size(),
                         ((g + mdist(nr, er) + mdist(nc, ec)) << 15) | (seq << 6) | nb);
              seq = (seq + 1) & 511;
            end
          end
        end
      end
      push_miss();
    endfunction

    function void check_cell(path_cell_t got);
      path_cell_t want;
      if (pending.size() == 0) begin
        $error("unexpected path cell %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.row !== want.row) begin
        $error("path_row expected %0d got %0d", want.row, got.row);
        errors++;
      end
      if (got.col !== want.col) begin
        $error("path_col expected %0d got %0d", want.col, got.col);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("path_found expected %0d got %0d", want.found, got.found);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_path expected %0d got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic opcode_i = OP_WRITE;
  logic [COORD_W-1:0] cell_row_i = '0, cell_col_i = '0;
  logic [CVAL_W-1:0] cell_value_i = '0;
  logic [COORD_W-1:0] start_row_i = '0, start_col_i = '0, end_row_i = '0, end_col_i = '0;
  logic path_valid_o;
  logic [COORD_W-1:0] path_row_o, path_col_o;
  logic path_found_o, last_of_path_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_ROWS;
  logic [MASK_W-1:0] cfg_data_i = '0;

  path_scoreboard sb = new();
  int idle_cycles = 0;
  localparam int WATCHDOG = 100000;

  grid_astar_path_search DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check each strobed cell and watch for a stalled run
  always @(posedge clk_i) begin
    if (rst_ni && path_valid_o)
      sb.check_cell('{row: path_row_o, col: path_col_o, found: path_found_o,
                      last: last_of_path_o});
    if ((start_i && !busy_o) || path_valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("[grid_astar_path_search] ERROR");
      $finish;
    end
  end

  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    repeat (n) @(negedge clk_i);
  endtask

  // Present one item and hold it until accepted
  task automatic send_item(logic op, int cr, int cc, int cv, int sr, int sc, int er, int ec);
    opcode_i = op;
    cell_row_i = COORD_W'(cr);
    cell_col_i = COORD_W'(cc);
    cell_value_i = CVAL_W'(cv);
    start_row_i = COORD_W'(sr);
    start_col_i = COORD_W'(sc);
    end_row_i = COORD_W'(er);
    end_col_i = COORD_W'(ec);
    start_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    sb.note_item(op, cr, cc, cv, sr, sc, er, ec);
    @(negedge clk_i);
    start_i = 1'b0;
    if ($urandom_range(0, 3) != 0) gap();
  endtask

  task automatic write_cell(int r, int c, int v);
    send_item(OP_WRITE, r, c, v, $urandom_range(0, 7), $urandom_range(0, 7),
              $urandom_range(0, 7), $urandom_range(0, 7));
  endtask

  task automatic query(int sr, int sc, int er, int ec);
    send_item(OP_QUERY, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 15),
              sr, sc, er, ec);
  endtask

  // Hold until every expected cell has come, then let the block settle
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    drain();
    cfg_index_i = idx;
    cfg_data_i = MASK_W'(data);
    cfg_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.set_reg(idx, MASK_W'(data));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_phase(int count, int hot);
    int a;
    for (int i = 0; i < count; i++) begin
      a = $urandom_range(0, 99);
      if (a < 55)
        write_cell($urandom_range(0, 7), $urandom_range(0, 7),
                   ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : hot);
      else
        query($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
              $urandom_range(0, 7));
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: default grid of zeros, walls, same cell, corners
    query(0, 0, 7, 7);
    query(7, 7, 0, 0);
    query(3, 4, 3, 4);
    write_cell(7, 7, 15);
    write_cell(0, 1, 1);
    write_cell(1, 0, 1);
    query(0, 0, 7, 7);
    query(0, 0, 1, 1);
    query(7, 7, 7, 6);
    write_cell(3, 3, 2);
    write_cell(3, 4, 3);
    query(0, 7, 7, 0);
    write_reg(CFG_ROWS, 4);
    write_reg(CFG_COLS, 3);
    query(0, 0, 3, 2);
    query(0, 0, 4, 2);
    query(0, 3, 0, 0);
    write_reg(CFG_ROWS, 0);
    query(0, 0, 0, 0);
    write_reg(CFG_ROWS, 15);
    write_reg(CFG_COLS, 1);
    query(0, 0, 7, 0);
    write_reg(CFG_COLS, 15);
    write_reg(CFG_MASK, 16'h0000);
    query(2, 2, 2, 3);
    query(5, 5, 5, 5);
    write_reg(CFG_MASK, 16'hFFFF);
    query(0, 0, 7, 7);

    // Random phases over several settings
    write_reg(CFG_MASK, 16'h0003);
    random_phase(50, 0);
    drain();
    write_reg(CFG_ROWS, $urandom_range(1, 8));
    write_reg(CFG_COLS, $urandom_range(1, 8));
    write_reg(CFG_MASK, $urandom_range(0, 65535) | 16'h0001);
    random_phase(45, 0);
    write_reg(CFG_ROWS, 8);
    write_reg(CFG_COLS, 8);
    write_reg(CFG_MASK, 16'h7FFF);
    random_phase(45, 15);
    write_reg(CFG_ROWS, 1);
    write_reg(CFG_COLS, 8);
    write_reg(CFG_MASK, 16'h8000);
    random_phase(20, 15);
    write_reg(CFG_ROWS, 8);
    write_reg(CFG_COLS, 2);
    write_reg(CFG_MASK, $urandom_range(0, 65535));
    random_phase(45, $urandom_range(0, 15));

    drain();
    repeat (200) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[grid_astar_path_search] OK");
    else
      $display("[grid_astar_path_search] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
